// ===== src/msd_pkg.sv =====
// ----------------------------------------------------------------------------
// msd_pkg: shared types and constants of the morse symbol class decoder
// Class codes, queue entry and status structs, the letter lookup.
// ----------------------------------------------------------------------------
package msd_pkg;

  localparam int unsigned ScoreWidth        = 16;
  localparam int unsigned CharWidth         = 7;
  localparam int unsigned CountWidth        = 3;
  localparam int unsigned PatternWidth      = 4;
  localparam int unsigned QueueDepthDefault = 2;

  localparam logic [CountWidth-1:0] MaxSymbols   = 3'd4;
  localparam logic [CountWidth-1:0] CountTooLong = 3'd5;

  localparam logic [ScoreWidth-1:0] ThresholdReset = 16'd16384;

  localparam logic [CharWidth-1:0] CharSpace   = 7'h20;
  localparam logic [CharWidth-1:0] CharUnknown = 7'h3F;

  // letters by code length 1..4, entry at (2^len - 2) + pattern
  localparam logic [CharWidth-1:0] LetterTable [30] = '{
    7'h45, 7'h54,
    7'h49, 7'h4E, 7'h41, 7'h4D,
    7'h53, 7'h44, 7'h52, 7'h47, 7'h55, 7'h4B, 7'h57, 7'h4F,
    7'h48, 7'h42, 7'h4C, 7'h5A, 7'h46, 7'h43, 7'h50, 7'h3F,
    7'h56, 7'h58, 7'h3F, 7'h51, 7'h3F, 7'h59, 7'h4A, 7'h3F
  };

  typedef enum logic [2:0] {
    CLS_DOT   = 3'd0,
    CLS_GAP   = 3'd1,
    CLS_DASH  = 3'd2,
    CLS_BLANK = 3'd3,
    CLS_NONE  = 3'd4
  } cls_e;

  typedef struct packed {
    logic avail;
    cls_e cls;
  } head_t;

  typedef struct packed {
    logic [CountWidth-1:0]   sym_count;
    logic [PatternWidth-1:0] sym_pattern;
  } dec_status_t;

  function automatic logic [CharWidth-1:0] decode_letter(
    input logic [CountWidth-1:0]   count,
    input logic [PatternWidth-1:0] pattern
  );
    logic [4:0]           idx;
    logic [CharWidth-1:0] letter;
    idx    = 5'd0;
    letter = CharUnknown;
    case (count)
      3'd1: begin
        idx    = {4'd0, pattern[0]};
        letter = LetterTable[idx];
      end
      3'd2: begin
        idx    = 5'd2 + {3'd0, pattern[1:0]};
        letter = LetterTable[idx];
      end
      3'd3: begin
        idx    = 5'd6 + {2'd0, pattern[2:0]};
        letter = LetterTable[idx];
      end
      3'd4: begin
        idx    = 5'd14 + {1'b0, pattern};
        letter = LetterTable[idx];
      end
      default: begin
        letter = CharUnknown;
      end
    endcase
    return letter;
  endfunction

endpackage

// ===== src/msd_if.sv =====
// ----------------------------------------------------------------------------
// msd_if: score and character channels
// Valid/ready channels carrying one window of scores and one character.
// ----------------------------------------------------------------------------
interface msd_score_if;
  logic        valid;
  logic        ready;
  logic [15:0] score_dot;
  logic [15:0] score_gap;
  logic [15:0] score_dash;
  logic [15:0] score_blank;

  modport source (output valid, output score_dot, output score_gap,
                  output score_dash, output score_blank, input ready);
  modport sink   (input valid, input score_dot, input score_gap,
                  input score_dash, input score_blank, output ready);
endinterface

interface msd_char_if;
  logic       valid;
  logic       ready;
  logic [6:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

// ===== src/msd_classifier.sv =====
// ----------------------------------------------------------------------------
// msd_classifier: front end
// Accepts score windows, holds the threshold and picks the winning class.
// ----------------------------------------------------------------------------
module msd_classifier (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [msd_pkg::ScoreWidth-1:0] cfg_wdata_i,
  msd_score_if.sink                   score_i,
  input  logic                        full_i,
  output logic                        push_o,
  output msd_pkg::cls_e               cls_o
);
  import msd_pkg::*;

  logic [ScoreWidth-1:0] thr_q;
  logic [ScoreWidth-1:0] scores [4];
  logic [ScoreWidth-1:0] best;
  cls_e                  win;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThresholdReset;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  assign scores[0] = score_i.score_dot;
  assign scores[1] = score_i.score_gap;
  assign scores[2] = score_i.score_dash;
  assign scores[3] = score_i.score_blank;

  // strict compare keeps the earlier class on a tie
  always_comb begin
    best = '0;
    win  = CLS_NONE;
    for (int i = 0; i < 4; i++) begin
      if (scores[i] > best) begin
        best = scores[i];
        win  = cls_e'(3'(i));
      end
    end
    if (best < thr_q) begin
      win = CLS_BLANK;
    end
  end

  assign score_i.ready = !full_i;
  assign push_o        = score_i.valid && !full_i;
  assign cls_o         = win;

endmodule

// ===== src/msd_class_queue.sv =====
// ----------------------------------------------------------------------------
// msd_class_queue: class queue
// Short queue of classified windows between the front and back ends.
// ----------------------------------------------------------------------------
module msd_class_queue #(
  parameter int unsigned Depth = msd_pkg::QueueDepthDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  msd_pkg::cls_e                cls_i,
  input  logic                         pop_i,
  output logic                         full_o,
  output msd_pkg::head_t               head_o,
  output logic [$clog2(Depth+1)-1:0]   level_o
);
  import msd_pkg::*;

  localparam int unsigned PtrW   = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned LevelW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0]   PtrLast = PtrW'(Depth - 1);
  localparam logic [LevelW-1:0] LevelFull = LevelW'(Depth);

  cls_e              mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [LevelW-1:0] level_q, level_d;
  logic              do_pop;

  assign do_pop = pop_i && (level_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    level_d  = level_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      level_d = level_q + 1'b1;
    end else if (!push_i && do_pop) begin
      level_d = level_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cls_i;
    end
  end

  assign full_o       = (level_q == LevelFull);
  assign head_o.avail = (level_q != '0);
  assign head_o.cls   = mem_q[rd_ptr_q];
  assign level_o      = level_q;

endmodule

// ===== src/msd_decoder.sv =====
// ----------------------------------------------------------------------------
// msd_decoder: back end
// Builds the current code from dots and dashes and emits characters.
// ----------------------------------------------------------------------------
module msd_decoder (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  msd_pkg::head_t       head_i,
  output logic                 pop_o,
  msd_char_if.source           char_o,
  output msd_pkg::dec_status_t status_o
);
  import msd_pkg::*;

  logic [CountWidth-1:0]   count_q, count_d;
  logic [PatternWidth-1:0] pattern_q, pattern_d;
  logic                    out_valid_q, out_valid_d;
  logic [CharWidth-1:0]    out_char_q, out_char_d;
  logic                    out_free;
  logic                    emit;

  assign out_free = !out_valid_q || char_o.ready;
  assign pop_o    = head_i.avail && out_free;

  always_comb begin
    count_d    = count_q;
    pattern_d  = pattern_q;
    emit       = 1'b0;
    out_char_d = out_char_q;
    if (pop_o) begin
      case (head_i.cls)
        CLS_DOT, CLS_DASH: begin
          if (count_q < MaxSymbols) begin
            pattern_d[count_q[1:0]] = (head_i.cls == CLS_DASH);
            count_d                 = count_q + 1'b1;
          end else begin
            count_d = CountTooLong;
          end
        end
        CLS_BLANK: begin
          if (count_q != '0) begin
            emit       = 1'b1;
            out_char_d = decode_letter(count_q, pattern_q);
            count_d    = '0;
            pattern_d  = '0;
          end
        end
        CLS_GAP: begin
          emit       = 1'b1;
          out_char_d = CharSpace;
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
    out_valid_d = pop_o ? emit : (out_valid_q && !char_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      pattern_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      pattern_q   <= pattern_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_char_q <= out_char_d;
  end

  assign char_o.valid       = out_valid_q;
  assign char_o.char_code   = out_char_q;
  assign status_o.sym_count   = count_q;
  assign status_o.sym_pattern = pattern_q;

endmodule

// ===== src/morse_symbol_class_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// morse_symbol_class_decoder_unit: morse decoder from classifier scores
// Front end classifies score windows, back end assembles letters.
// ----------------------------------------------------------------------------
// Each item is one window of four Q1.15 scores (dot, word gap, dash, blank).
// The highest score strictly above zero wins, the earlier class on a tie; a
// winner below the threshold register counts as blank. Dots and dashes build
// the current code (five or more symbols decode as '?'), a blank closes a
// non-empty code and emits its letter, a word gap emits a space. One item is
// accepted per cycle while the queue is not full: the classifier is
// combinational, and a queue of QueueDepth entries and a registered output let
// the back end take one item a cycle while the output drains; each result shows
// in the cycle after its pop. Write the threshold only while the block is idle.
module morse_symbol_class_decoder_unit #(
  parameter int unsigned QueueDepth = msd_pkg::QueueDepthDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [msd_pkg::ScoreWidth-1:0] cfg_wdata_i,
  msd_score_if.sink                      score_i,
  msd_char_if.source                     char_o
);
  import msd_pkg::*;

  localparam int unsigned LevelW = $clog2(QueueDepth + 1);

  logic              push;
  cls_e              push_cls;
  logic              full;
  logic              pop;
  head_t             head;
  logic [LevelW-1:0] level;
  dec_status_t       status;

  msd_classifier u_classifier (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .score_i     (score_i),
    .full_i      (full),
    .push_o      (push),
    .cls_o       (push_cls)
  );

  msd_class_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cls_i   (push_cls),
    .pop_i   (pop),
    .full_o  (full),
    .head_o  (head),
    .level_o (level)
  );

  msd_decoder u_decoder (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .pop_o    (pop),
    .char_o   (char_o),
    .status_o (status)
  );

`ifndef SYNTHESIS
  // symbol count never leaves 0..5
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.sym_count <= CountTooLong)
    else $error("symbol count out of range");

  // queue level never exceeds its depth
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level <= LevelW'(QueueDepth))
    else $error("class queue overflow");

  // no item leaves the queue while a stalled result is still held
  a_no_pop_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (char_o.valid && !char_o.ready) |-> !pop)
    else $error("pop while output stalled");

  // a too long code only clears through a blank, which leaves pattern zero
  a_clear_pattern: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status.sym_count == '0) |-> (status.sym_pattern == '0))
    else $error("pattern left over after clear");
`endif

endmodule

// ===== dv/morse_symbol_class_decoder_unit_tb.sv =====
// ----------------------------------------------------------------------------
// morse_symbol_class_decoder_unit_tb: self-checking bench of the morse decoder
// Offers score windows under several threshold settings, predicts every
// character from its own copy of the classifier and code state, and compares
// each character that leaves the block with the oldest prediction.
// ----------------------------------------------------------------------------
module morse_symbol_class_decoder_unit_tb;
  import msd_pkg::*;

  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned HoldCycles    = 150;
  localparam int unsigned ItemsPerPhase = 125;

  class morse_char_scoreboard;
    logic [ScoreWidth-1:0]   threshold;
    logic [CountWidth-1:0]   sym_count;
    logic [PatternWidth-1:0] sym_pattern;
    logic [CharWidth-1:0]    expected_chars [$];
    int unsigned             mismatches;

    function new();
      threshold   = 16'd16384;
      sym_count   = '0;
      sym_pattern = '0;
      mismatches  = 0;
    endfunction

    // bit i of the pattern is symbol i, dash is one
    function logic [CharWidth-1:0] letter_of();
      string row;
      byte   ch;
      case (sym_count)
        3'd1: row = "ET";
        3'd2: row = "INAM";
        3'd3: row = "SDRGUKWO";
        3'd4: row = "HBLZFCP?VX?Q?YJ?";
        default: return CharUnknown;
      endcase
      ch = row[int'(sym_pattern)];
      return ch[CharWidth-1:0];
    endfunction

    function void add_symbol(input logic dash);
      if (sym_count < MaxSymbols) begin
        sym_pattern[sym_count] = dash;
        sym_count = sym_count + 3'd1;
      end else begin
        sym_count = CountTooLong;
      end
    endfunction

    function void note_window(input logic [ScoreWidth-1:0] dot, gap, dash, blank);
      logic [ScoreWidth-1:0] scores [4];
      logic [ScoreWidth-1:0] best;
      cls_e                  winner;
      scores = '{dot, gap, dash, blank};
      best   = '0;
      winner = CLS_NONE;
      for (int i = 0; i < 4; i++) begin
        if (scores[i] > best) begin
          best   = scores[i];
          winner = cls_e'(i);
        end
      end
      if (best < threshold) winner = CLS_BLANK;
      case (winner)
        CLS_DOT:  add_symbol(1'b0);
        CLS_DASH: add_symbol(1'b1);
        CLS_BLANK: begin
          if (sym_count != '0) begin
            expected_chars.push_back(letter_of());
            sym_count   = '0;
            sym_pattern = '0;
          end
        end
        CLS_GAP:  expected_chars.push_back(CharSpace);
        default: ;
      endcase
    endfunction

    function void check_char(input logic [CharWidth-1:0] got);
      logic [CharWidth-1:0] want;
      if (expected_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("char 0x%02h with nothing pending", got);
      end else begin
        want = expected_chars.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("char mismatch: expected 0x%02h actual 0x%02h", want, got);
        end
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [ScoreWidth-1:0] cfg_wdata_i;
  bit                    hold_req;

  msd_score_if score_if ();
  msd_char_if  char_if ();

  morse_char_scoreboard sb = new();

  morse_symbol_class_decoder_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .score_i     (score_if),
    .char_o      (char_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // character checked before the window of the same edge is noted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (char_if.valid && char_if.ready) sb.check_char(char_if.char_code);
      if (score_if.valid && score_if.ready)
        sb.note_window(score_if.score_dot, score_if.score_gap,
                       score_if.score_dash, score_if.score_blank);
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic offer_window(input logic [ScoreWidth-1:0] dot, gap, dash, blank,
                              input bit eager);
    int unsigned idle;
    idle = eager ? 0 : pick_gap();
    if (idle != 0) begin
      score_if.valid <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    score_if.valid       <= 1'b1;
    score_if.score_dot   <= dot;
    score_if.score_gap   <= gap;
    score_if.score_dash  <= dash;
    score_if.score_blank <= blank;
    do @(posedge clk_i); while (!score_if.ready);
  endtask

  // a window whose winner is the given class at the current threshold
  task automatic send_class(input cls_e c, input bit eager);
    logic [ScoreWidth-1:0] s [4];
    int unsigned           lo;
    int unsigned           win;
    lo = (sb.threshold == '0) ? 1 : sb.threshold;
    if (c == CLS_BLANK && sb.threshold > 1 && $urandom_range(0, 2) == 0) begin
      // a weak winner of any class still closes the code
      win = $urandom_range(1, sb.threshold - 1);
      c   = cls_e'($urandom_range(0, 3));
    end else begin
      win = $urandom_range(lo, 32768);
    end
    foreach (s[i]) s[i] = 16'($urandom_range(0, win - 1));
    s[int'(c)] = 16'(win);
    offer_window(s[0], s[1], s[2], s[3], eager);
  endtask

  task automatic send_noise();
    logic [ScoreWidth-1:0] s [4];
    foreach (s[i]) begin
      case ($urandom_range(0, 7))
        0: s[i] = '0;
        1: s[i] = 16'd32768;
        2: s[i] = 16'($urandom_range(32769, 65535));
        default: s[i] = 16'($urandom_range(0, 32768));
      endcase
    end
    if ($urandom_range(0, 3) == 0) s[$urandom_range(1, 3)] = s[$urandom_range(0, 2)];
    if ($urandom_range(0, 9) == 0) s = '{default: '0};
    offer_window(s[0], s[1], s[2], s[3], 1'b0);
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned sent;
    int unsigned len;
    int unsigned r;
    sent = 0;
    while (sent < count) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        // a letter, now and then too long
        len = (r < 7) ? $urandom_range(5, 7) : $urandom_range(1, 4);
        repeat (len) send_class($urandom_range(0, 1) ? CLS_DASH : CLS_DOT, 1'b0);
        send_class(CLS_BLANK, 1'b0);
        sent += len + 1;
      end else if (r < 85) begin
        send_class(CLS_GAP, 1'b0);
        sent++;
      end else begin
        send_noise();
        sent++;
      end
    end
  endtask

  task automatic wait_idle();
    score_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_chars.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [ScoreWidth-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.threshold = value;
  endtask

  // receiver: bursts of ready with random stalls, one long hold-off on request
  initial begin
    int unsigned stall;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        char_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      char_if.ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
      stall = pick_gap();
      if (stall != 0) begin
        char_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  initial begin
    logic [ScoreWidth-1:0] thr_list [5];
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_wdata_i          = '0;
    hold_req             = 1'b0;
    score_if.valid       = 1'b0;
    score_if.score_dot   = '0;
    score_if.score_gap   = '0;
    score_if.score_dash  = '0;
    score_if.score_blank = '0;
    char_if.ready        = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed windows at the reset threshold
    offer_window('0, '0, '0, '0, 1'b0);                        // no winner, empty code
    offer_window(16'd32768, '0, '0, '0, 1'b0);
    offer_window('0, '0, '0, 16'd32768, 1'b0);                 // E
    offer_window(16'd20000, '0, 16'd20000, '0, 1'b0);          // tie goes to dot
    offer_window('0, 16'd30000, 16'd30000, '0, 1'b0);          // tie goes to word gap
    offer_window('0, '0, '0, 16'd16384, 1'b0);                 // E, code kept by gap
    offer_window(16'd16383, '0, '0, '0, 1'b0);                 // just under threshold
    offer_window(16'd40000, '0, 16'd65535, '0, 1'b0);          // scores above one
    offer_window(16'd16384, '0, '0, '0, 1'b0);                 // exactly at threshold
    offer_window(16'd32768, '0, '0, '0, 1'b0);
    offer_window('0, '0, 16'd32768, '0, 1'b0);
    offer_window('0, '0, '0, 16'd100, 1'b0);                   // weak blank closes X
    offer_window(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    repeat (5) offer_window('0, '0, 16'd32768, '0, 1'b0);      // too long
    offer_window('0, '0, '0, 16'd32768, 1'b0);
    offer_window(16'd32768, '0, '0, '0, 1'b0);
    offer_window(16'd32768, '0, '0, '0, 1'b0);
    offer_window('0, '0, 16'd32768, '0, 1'b0);
    offer_window('0, '0, 16'd32768, '0, 1'b0);
    offer_window('0, '0, '0, 16'd32768, 1'b0);                 // unknown four-symbol code
    wait_idle();

    thr_list = '{16'd1, 16'd32768, 16'd0, 16'($urandom_range(2, 32767)), 16'd16384};
    foreach (thr_list[p]) begin
      write_threshold(thr_list[p]);
      if (thr_list[p] == '0) begin
        // with no threshold an all-zero window does nothing at all
        offer_window(16'd1, '0, '0, '0, 1'b0);
        offer_window('0, '0, '0, '0, 1'b0);
        offer_window('0, 16'd1, '0, '0, 1'b0);
        offer_window('0, '0, '0, 16'd1, 1'b0);
      end
      if (p == 3) begin
        // keep offering while the receiver holds off
        hold_req = 1'b1;
        do send_class(cls_e'($urandom_range(0, 3)), 1'b1); while (hold_req);
        repeat (40) send_class(cls_e'($urandom_range(0, 3)), 1'b1);
      end
      run_random(ItemsPerPhase);
      wait_idle();
    end

    if (sb.mismatches == 0 && sb.expected_chars.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
